>>> rtl/core/hlc_pkg.sv
package hlc_pkg;

  // default number of cores in the table
  localparam int unsigned CoreCountDefault = 8;
  // widths fixed by the item format
  localparam int unsigned CoreIdxW = 4;
  localparam int unsigned AddrW    = 64;
  localparam int unsigned BootMaskW = 8;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 64;

  // lifecycle status codes
  typedef enum logic [1:0] {
    StStopped  = 2'd0,
    StStarting = 2'd1,
    StStarted  = 2'd2,
    StInvalid  = 2'd3
  } status_e;

  // operation codes carried in the mode field
  typedef enum logic [1:0] {
    ModeQuery = 2'd0,
    ModeStart = 2'd1,
    ModeStop  = 2'd2,
    ModeIrq   = 2'd3
  } mode_e;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgParkAddr = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgBootMask = CfgIdxW'(1);

  typedef struct packed {
    logic [1:0]          mode;
    logic [CoreIdxW-1:0] core_index;
    logic [AddrW-1:0]    start_address;
    logic [AddrW-1:0]    scratch_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       core_status;
    logic             accepted;
    logic             raise_soft_irq;
    logic             clear_soft_irq;
    logic             redirect;
    logic [AddrW-1:0] resume_address;
    logic             resume_supervisor;
    logic             load_scratch;
    logic [AddrW-1:0] resume_scratch;
  } out_item_t;

  // status table write port
  typedef struct packed {
    logic                en;
    logic [CoreIdxW-1:0] core;
    status_e             status;
  } st_wr_t;

  // context table write port
  typedef struct packed {
    logic                en;
    logic [CoreIdxW-1:0] core;
    logic [AddrW-1:0]    addr;
    logic [AddrW-1:0]    scratch;
  } ctx_wr_t;

  // status a core takes after reset or a boot mask reload
  function automatic status_e boot_status(input logic [BootMaskW-1:0] mask,
                                          input logic [CoreIdxW-1:0] core);
    status_e st;
    st = StStopped;
    if (core < CoreIdxW'(BootMaskW) && mask[core[2:0]]) begin
      st = StStarted;
    end
    return st;
  endfunction

endpackage

>>> rtl/core/hlc_status_store.sv
module hlc_status_store #(
  parameter int unsigned CORE_COUNT = hlc_pkg::CoreCountDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               rd_en_i,
  input  logic [hlc_pkg::CoreIdxW-1:0]       rd_core_i,
  input  logic [hlc_pkg::BootMaskW-1:0]      boot_mask_i,
  input  logic                               reload_i,
  input  hlc_pkg::st_wr_t                    wr_i,
  output hlc_pkg::status_e                   rd_status_o
);

  localparam int unsigned IdxW = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1;

  hlc_pkg::status_e          mem_q [CORE_COUNT];
  logic [CORE_COUNT-1:0]     valid_q;
  hlc_pkg::status_e          rd_status_q;

  // entry storage, no reset
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.core[IdxW-1:0]] <= wr_i.status;
    end
  end

  // registered read, unwritten entries fall back to the boot mask
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (valid_q[rd_core_i[IdxW-1:0]]) begin
        rd_status_q <= mem_q[rd_core_i[IdxW-1:0]];
      end else begin
        rd_status_q <= hlc_pkg::boot_status(boot_mask_i, rd_core_i);
      end
    end
  end

  // per-entry valid bits, dropped on a mask reload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (reload_i) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.core[IdxW-1:0]] <= 1'b1;
    end
  end

  assign rd_status_o = rd_status_q;

endmodule

>>> rtl/core/hlc_context_store.sv
module hlc_context_store #(
  parameter int unsigned CORE_COUNT = hlc_pkg::CoreCountDefault
) (
  input  logic                          clk_i,
  input  logic                          rd_en_i,
  input  logic [hlc_pkg::CoreIdxW-1:0]  rd_core_i,
  input  hlc_pkg::ctx_wr_t              wr_i,
  output logic [hlc_pkg::AddrW-1:0]     rd_addr_o,
  output logic [hlc_pkg::AddrW-1:0]     rd_scratch_o
);

  localparam int unsigned IdxW = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1;
  localparam int unsigned EntW = 2 * hlc_pkg::AddrW;

  logic [EntW-1:0] mem_q [CORE_COUNT];
  logic [EntW-1:0] rd_q;

  // start address and scratch word, one entry per core
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.core[IdxW-1:0]] <= {wr_i.addr, wr_i.scratch};
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_core_i[IdxW-1:0]];
    end
  end

  assign rd_addr_o    = rd_q[EntW-1:hlc_pkg::AddrW];
  assign rd_scratch_o = rd_q[hlc_pkg::AddrW-1:0];

endmodule

>>> rtl/core/hart_lifecycle_controller.sv
// channel | direction | handshake                  | payload
// in      | input     | in_valid_i / in_ready_o    | in_item_i (hlc_pkg::in_item_t)
// out     | output    | out_valid_o / out_ready_i  | out_item_o (hlc_pkg::out_item_t)
// cfg     | input     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// an item is handled in steps: the accept edge reads both tables, then the exec
// step writes back and loads the output register
// reset brings park address 0, boot mask 1 and all cores per the mask
// a waiting result stalls the write-back step; the next item can be accepted
// while a result waits, and cfg writes are always taken
module hart_lifecycle_controller #(
  parameter int unsigned CORE_COUNT = hlc_pkg::CoreCountDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  hlc_pkg::in_item_t              in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output hlc_pkg::out_item_t             out_item_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [hlc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [hlc_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam logic StateIdle = 1'b0;
  localparam logic StateExec = 1'b1;

  logic                           state_q, state_d;
  logic                           out_valid_q;
  hlc_pkg::out_item_t             out_q, out_d;
  hlc_pkg::in_item_t              item_q;
  logic [hlc_pkg::AddrW-1:0]      park_q;
  logic [hlc_pkg::BootMaskW-1:0]  mask_q;

  logic                           in_fire, out_fire, cfg_fire, exec_fire;
  logic                           rd_in_range, ex_in_range;
  hlc_pkg::status_e               rd_status, new_status;
  logic [hlc_pkg::AddrW-1:0]      ctx_addr, ctx_scratch;
  hlc_pkg::st_wr_t                st_wr;
  hlc_pkg::ctx_wr_t               ctx_wr;

  assign in_fire   = in_valid_i && in_ready_o;
  assign out_fire  = out_valid_q && out_ready_i;
  assign cfg_fire  = cfg_valid_i && cfg_ready_o;
  assign exec_fire = (state_q == StateExec) && (!out_valid_q || out_ready_i);

  assign in_ready_o  = (state_q == StateIdle);
  assign cfg_ready_o = 1'b1;

  assign rd_in_range = {1'b0, in_item_i.core_index} < (hlc_pkg::CoreIdxW + 1)'(CORE_COUNT);
  assign ex_in_range = {1'b0, item_q.core_index} < (hlc_pkg::CoreIdxW + 1)'(CORE_COUNT);

  // table instances
  hlc_status_store #(
    .CORE_COUNT (CORE_COUNT)
  ) u_status (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (in_fire && rd_in_range),
    .rd_core_i   (in_item_i.core_index),
    .boot_mask_i (mask_q),
    .reload_i    (cfg_fire && (cfg_index_i == hlc_pkg::CfgBootMask)),
    .wr_i        (st_wr),
    .rd_status_o (rd_status)
  );

  hlc_context_store #(
    .CORE_COUNT (CORE_COUNT)
  ) u_context (
    .clk_i        (clk_i),
    .rd_en_i      (in_fire && rd_in_range),
    .rd_core_i    (in_item_i.core_index),
    .wr_i         (ctx_wr),
    .rd_addr_o    (ctx_addr),
    .rd_scratch_o (ctx_scratch)
  );

  // operation decode on the read data
  always_comb begin
    out_d      = '0;
    new_status = rd_status;
    if (!ex_in_range) begin
      out_d.core_status = hlc_pkg::StInvalid;
    end else begin
      unique case (item_q.mode)
        hlc_pkg::ModeStart: begin
          if (rd_status == hlc_pkg::StStopped) begin
            new_status           = hlc_pkg::StStarting;
            out_d.raise_soft_irq = 1'b1;
            out_d.accepted       = 1'b1;
          end
        end
        hlc_pkg::ModeStop: begin
          if (rd_status == hlc_pkg::StStarted) begin
            new_status           = hlc_pkg::StStopped;
            out_d.redirect       = 1'b1;
            out_d.resume_address = park_q;
            out_d.accepted       = 1'b1;
          end
        end
        hlc_pkg::ModeIrq: begin
          out_d.clear_soft_irq = 1'b1;
          if (rd_status == hlc_pkg::StStarting) begin
            new_status              = hlc_pkg::StStarted;
            out_d.redirect          = 1'b1;
            out_d.resume_address    = ctx_addr;
            out_d.resume_supervisor = 1'b1;
            out_d.load_scratch      = 1'b1;
            out_d.resume_scratch    = ctx_scratch;
          end
        end
        default: begin
        end
      endcase
      out_d.core_status = new_status;
    end
  end

  // write-back ports
  always_comb begin
    st_wr.en       = exec_fire && ex_in_range && (new_status != rd_status);
    st_wr.core     = item_q.core_index;
    st_wr.status   = new_status;
    ctx_wr.en      = exec_fire && ex_in_range && (item_q.mode == hlc_pkg::ModeStart)
                     && (rd_status == hlc_pkg::StStopped);
    ctx_wr.core    = item_q.core_index;
    ctx_wr.addr    = item_q.start_address;
    ctx_wr.scratch = item_q.scratch_value;
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StateIdle: if (in_fire)   state_d = StateExec;
      StateExec: if (exec_fire) state_d = StateIdle;
      default:   state_d = StateIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (exec_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item and result registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_item_i;
    end
    if (exec_fire) begin
      out_q <= out_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      park_q <= '0;
      mask_q <= hlc_pkg::BootMaskW'(1);
    end else if (cfg_fire) begin
      if (cfg_index_i == hlc_pkg::CfgParkAddr) begin
        park_q <= cfg_data_i;
      end
      if (cfg_index_i == hlc_pkg::CfgBootMask) begin
        mask_q <= cfg_data_i[hlc_pkg::BootMaskW-1:0];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef NO_ASSERTIONS
  a_accept_to_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == StateExec) && !in_ready_o)
    else $error("accepted item did not enter the exec step");

  a_exec_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire |=> out_valid_o)
    else $error("exec step produced no result");

  a_invalid_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.core_status == hlc_pkg::StInvalid) |->
      !out_item_o.accepted && !out_item_o.redirect &&
      !out_item_o.raise_soft_irq && !out_item_o.clear_soft_irq)
    else $error("invalid core produced side effects");

  a_scratch_launch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.load_scratch |->
      out_item_o.redirect && out_item_o.resume_supervisor &&
      (out_item_o.core_status == hlc_pkg::StStarted))
    else $error("scratch load without a supervisor launch");
`endif

endmodule
